// ----- src/bba_pkg.sv -----
// Package: shared types and constants of the buddy block allocator.
`timescale 1ns / 1ps

package bba_pkg;

    localparam int HEAP_BITS_DEF      = 16;
    localparam int MIN_BLOCK_BITS_DEF = 5;

    localparam int SIZE_W  = 17;
    localparam int OFF_W   = 16;
    localparam int ORDER_W = 4;
    localparam int NEED_W  = SIZE_W + 1;
    localparam int TAG_W   = 5;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        RC_OK        = 2'd0,
        RC_TOO_LARGE = 2'd1,
        RC_NO_FREE   = 2'd2,
        RC_BAD_FREE  = 2'd3
    } result_code_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SIZE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SPLIT,
        S_FCHK,
        S_FTAG,
        S_MERGE_RD,
        S_MERGE_CHK,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic         load;
        logic         clr_step;
        logic         k_inc;
        logic         scan_init;
        logic         p_inc;
        logic         j_next;
        logic         take;
        logic         split;
        logic         ftag;
        logic         buddy_rd;
        logic         merge;
        logic         set_code;
        result_code_t code;
        logic         finish;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_free_op;
        logic fits;
        logic k_top;
        logic node_bit;
        logic p_last;
        logic j_top;
        logic j_gt_k;
        logic bad_off;
        logic tag_bad;
        logic out_busy;
    } stat_t;

endpackage

// ----- src/buddy_block_allocator.sv -----
// Allocate: find the needed order k, scan tree nodes from order k upward for a free one, then
// split it down to order k; a request too large or with no free block gets an error status.
// Free: check offset and order tag, then merge with free buddies toward the whole heap;
// a bad offset or tag gets an error status. One transaction is in work at a time; the next is
// taken the cycle after the result register loads, while that result may still wait there.
// After reset a clearing pass initializes the tree bits and order tags.
`timescale 1ns / 1ps

module buddy_block_allocator
#(
    parameter int HEAP_BITS      = bba_pkg::HEAP_BITS_DEF,
    parameter int MIN_BLOCK_BITS = bba_pkg::MIN_BLOCK_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        operation,
    input  logic [bba_pkg::SIZE_W-1:0]  request_size,
    input  logic [bba_pkg::OFF_W-1:0]   block_offset,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [bba_pkg::OFF_W-1:0]   granted_offset,
    output logic [bba_pkg::ORDER_W-1:0] granted_order,
    output logic [1:0]                  status
);

    bba_pkg::cmd_t  cmd;
    bba_pkg::stat_t st;

    bba_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    bba_dpath
    #(
        .HEAP_BITS      (HEAP_BITS),
        .MIN_BLOCK_BITS (MIN_BLOCK_BITS)
    )
    u_dpath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .operation      (operation),
        .request_size   (request_size),
        .block_offset   (block_offset),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .granted_offset (granted_offset),
        .granted_order  (granted_order),
        .status         (status)
    );

endmodule

// ----- src/bba_ctrl.sv -----
// Controller state machine of the buddy block allocator.
`timescale 1ns / 1ps

module bba_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  bba_pkg::stat_t st,
    output bba_pkg::cmd_t  cmd
);

    bba_pkg::state_t state_reg;
    bba_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bba_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bba_pkg::S_CLEAR:
            begin
                if (st.clr_last)
                begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bba_pkg::S_DECODE;
                end
            end
            bba_pkg::S_DECODE:
            begin
                state_next = st.is_free_op ? bba_pkg::S_FCHK : bba_pkg::S_SIZE;
            end
            bba_pkg::S_SIZE:
            begin
                if (st.fits)
                begin
                    state_next = bba_pkg::S_SCAN_RD;
                end
                else if (st.k_top)
                begin
                    state_next = bba_pkg::S_RESULT;
                end
            end
            bba_pkg::S_SCAN_RD:
            begin
                state_next = bba_pkg::S_SCAN_CHK;
            end
            bba_pkg::S_SCAN_CHK:
            begin
                if (st.node_bit)
                begin
                    state_next = bba_pkg::S_SPLIT;
                end
                else if (st.p_last && st.j_top)
                begin
                    state_next = bba_pkg::S_RESULT;
                end
                else
                begin
                    state_next = bba_pkg::S_SCAN_RD;
                end
            end
            bba_pkg::S_SPLIT:
            begin
                if (!st.j_gt_k)
                begin
                    state_next = bba_pkg::S_RESULT;
                end
            end
            bba_pkg::S_FCHK:
            begin
                state_next = st.bad_off ? bba_pkg::S_RESULT : bba_pkg::S_FTAG;
            end
            bba_pkg::S_FTAG:
            begin
                state_next = st.tag_bad ? bba_pkg::S_RESULT : bba_pkg::S_MERGE_RD;
            end
            bba_pkg::S_MERGE_RD:
            begin
                state_next = st.j_top ? bba_pkg::S_RESULT : bba_pkg::S_MERGE_CHK;
            end
            bba_pkg::S_MERGE_CHK:
            begin
                state_next = st.node_bit ? bba_pkg::S_MERGE_RD : bba_pkg::S_RESULT;
            end
            bba_pkg::S_RESULT:
            begin
                if (!st.out_busy)
                begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.code = bba_pkg::RC_OK;
        in_stall = (state_reg != bba_pkg::S_IDLE);
        unique case (state_reg)
            bba_pkg::S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            bba_pkg::S_IDLE:
            begin
                cmd.load = in_valid;
            end
            bba_pkg::S_DECODE:
            begin
            end
            bba_pkg::S_SIZE:
            begin
                if (st.fits)
                begin
                    cmd.scan_init = 1'b1;
                end
                else if (st.k_top)
                begin
                    cmd.set_code = 1'b1;
                    cmd.code     = bba_pkg::RC_TOO_LARGE;
                end
                else
                begin
                    cmd.k_inc = 1'b1;
                end
            end
            bba_pkg::S_SCAN_RD:
            begin
            end
            bba_pkg::S_SCAN_CHK:
            begin
                if (st.node_bit)
                begin
                    cmd.take = 1'b1;
                end
                else if (st.p_last && st.j_top)
                begin
                    cmd.set_code = 1'b1;
                    cmd.code     = bba_pkg::RC_NO_FREE;
                end
                else if (st.p_last)
                begin
                    cmd.j_next = 1'b1;
                end
                else
                begin
                    cmd.p_inc = 1'b1;
                end
            end
            bba_pkg::S_SPLIT:
            begin
                cmd.split = st.j_gt_k;
            end
            bba_pkg::S_FCHK:
            begin
                if (st.bad_off)
                begin
                    cmd.set_code = 1'b1;
                    cmd.code     = bba_pkg::RC_BAD_FREE;
                end
            end
            bba_pkg::S_FTAG:
            begin
                if (st.tag_bad)
                begin
                    cmd.set_code = 1'b1;
                    cmd.code     = bba_pkg::RC_BAD_FREE;
                end
                else
                begin
                    cmd.ftag = 1'b1;
                end
            end
            bba_pkg::S_MERGE_RD:
            begin
                cmd.buddy_rd = 1'b1;
            end
            bba_pkg::S_MERGE_CHK:
            begin
                cmd.merge = st.node_bit;
            end
            bba_pkg::S_RESULT:
            begin
                cmd.finish = !st.out_busy;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- src/bba_dpath.sv -----
// Datapath of the buddy block allocator: tree bits, order tags, cursors, result register.
`timescale 1ns / 1ps

module bba_dpath
#(
    parameter int HEAP_BITS      = bba_pkg::HEAP_BITS_DEF,
    parameter int MIN_BLOCK_BITS = bba_pkg::MIN_BLOCK_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  bba_pkg::cmd_t               cmd,
    output bba_pkg::stat_t              st,
    input  logic                        operation,
    input  logic [bba_pkg::SIZE_W-1:0]  request_size,
    input  logic [bba_pkg::OFF_W-1:0]   block_offset,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [bba_pkg::OFF_W-1:0]   granted_offset,
    output logic [bba_pkg::ORDER_W-1:0] granted_order,
    output logic [1:0]                  status
);

    localparam int TOP   = HEAP_BITS - MIN_BLOCK_BITS;
    localparam int NAW   = TOP + 1;
    localparam int PW    = TOP + 1;
    localparam int ORD_W = $clog2(TOP + 2);
    localparam logic [NAW-1:0] CLR_LAST = {{(NAW - 1){1'b1}}, 1'b0};
    localparam logic [ORD_W-1:0] TOP_ORD = ORD_W'(TOP);

    logic [bba_pkg::TAG_W-1:0] tag_mem [2**TOP];
    logic                      node_mem [2**NAW];

    logic                          op_reg;
    logic [bba_pkg::NEED_W-1:0]    need_reg;
    logic [bba_pkg::OFF_W-1:0]     off_reg;
    logic [ORD_W-1:0]              k_reg;
    logic [ORD_W-1:0]              j_reg;
    logic [PW-1:0]                 p_reg;
    logic [NAW-1:0]                clr_cnt_reg;
    bba_pkg::result_code_t         code_reg;
    logic                          node_rdata_reg;
    logic [bba_pkg::TAG_W-1:0]     tag_rdata_reg;
    logic                          out_valid_reg;
    logic [bba_pkg::OFF_W-1:0]     res_off_reg;
    logic [bba_pkg::ORDER_W-1:0]   res_ord_reg;
    logic [1:0]                    res_code_reg;

    logic [NAW:0]                  base_j;
    logic [NAW:0]                  node_jp;
    logic [NAW:0]                  node_split;
    logic [NAW:0]                  node_buddy;
    logic [PW-1:0]                 p_child;
    logic [TOP-1:0]                leaf;
    logic [31:0]                   blk_size;
    logic [31:0]                   res_off32;
    logic [31:0]                   tag_leaf32;
    logic [ORD_W-1:0]              tag_ord;
    logic                          node_we;
    logic [NAW-1:0]                node_waddr;
    logic                          node_wdata;
    logic [NAW-1:0]                node_raddr;
    logic                          tag_we;
    logic [TOP-1:0]                tag_waddr;
    logic [bba_pkg::TAG_W-1:0]     tag_wdata;
    logic                          pop;
    logic                          ok_alloc;
    logic                          ok_free;

    assign base_j     = (NAW + 1)'(1) << (TOP_ORD - j_reg);
    assign node_jp    = base_j - (NAW + 1)'(1) + {1'b0, p_reg};
    assign p_child    = {p_reg[PW-2:0], 1'b1};
    assign node_split = (base_j << 1) - (NAW + 1)'(1) + {1'b0, p_child};
    assign node_buddy = base_j - (NAW + 1)'(1) + {1'b0, p_reg ^ PW'(1)};
    assign leaf       = TOP'(32'(off_reg) >> MIN_BLOCK_BITS);
    assign blk_size   = 32'(1) << (32'(k_reg) + MIN_BLOCK_BITS);
    assign res_off32  = 32'(p_reg) << (32'(j_reg) + MIN_BLOCK_BITS);
    assign tag_leaf32 = 32'(p_reg) << j_reg;
    assign tag_ord    = ORD_W'(tag_rdata_reg - bba_pkg::TAG_W'(1));
    assign pop        = out_valid_reg && !out_stall;
    assign ok_alloc   = cmd.finish && code_reg == bba_pkg::RC_OK && op_reg == bba_pkg::OP_ALLOC;
    assign ok_free    = cmd.finish && code_reg == bba_pkg::RC_OK && op_reg == bba_pkg::OP_FREE;

    always_comb
    begin
        st.clr_last   = (clr_cnt_reg == CLR_LAST);
        st.is_free_op = (op_reg == bba_pkg::OP_FREE);
        st.fits       = (blk_size >= 32'(need_reg));
        st.k_top      = (k_reg == TOP_ORD);
        st.node_bit   = node_rdata_reg;
        st.p_last     = ({1'b0, p_reg} == base_j - (NAW + 1)'(1));
        st.j_top      = (j_reg == TOP_ORD);
        st.j_gt_k     = (j_reg > k_reg);
        st.bad_off    = ((32'(off_reg) >> HEAP_BITS) != 32'd0)
                        || (off_reg[MIN_BLOCK_BITS-1:0] != '0);
        st.tag_bad    = (tag_rdata_reg == '0) || (32'(tag_rdata_reg) > TOP + 1);
        st.out_busy   = out_valid_reg && out_stall;
    end

    always_comb
    begin
        node_we    = 1'b0;
        node_waddr = node_jp[NAW-1:0];
        node_wdata = 1'b0;
        if (cmd.clr_step)
        begin
            node_we    = 1'b1;
            node_waddr = clr_cnt_reg;
            node_wdata = (clr_cnt_reg == '0);
        end
        else if (cmd.take)
        begin
            node_we = 1'b1;
        end
        else if (cmd.split)
        begin
            node_we    = 1'b1;
            node_waddr = node_split[NAW-1:0];
            node_wdata = 1'b1;
        end
        else if (cmd.merge)
        begin
            node_we    = 1'b1;
            node_waddr = node_buddy[NAW-1:0];
        end
        else if (ok_free)
        begin
            node_we    = 1'b1;
            node_wdata = 1'b1;
        end
        node_raddr = cmd.buddy_rd ? node_buddy[NAW-1:0] : node_jp[NAW-1:0];
    end

    always_comb
    begin
        tag_we    = 1'b0;
        tag_waddr = leaf;
        tag_wdata = '0;
        if (cmd.clr_step)
        begin
            tag_we    = !clr_cnt_reg[NAW-1];
            tag_waddr = clr_cnt_reg[TOP-1:0];
        end
        else if (cmd.ftag)
        begin
            tag_we = 1'b1;
        end
        else if (ok_alloc)
        begin
            tag_we    = 1'b1;
            tag_waddr = tag_leaf32[TOP-1:0];
            tag_wdata = bba_pkg::TAG_W'(32'(j_reg) + 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_rdata_reg <= node_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        tag_rdata_reg <= tag_mem[leaf];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            need_reg <= bba_pkg::NEED_W'(request_size) + bba_pkg::NEED_W'(1);
            off_reg  <= block_offset;
        end
        if (cmd.load)
        begin
            k_reg <= '0;
        end
        else if (cmd.k_inc)
        begin
            k_reg <= k_reg + ORD_W'(1);
        end
        if (cmd.scan_init)
        begin
            j_reg <= k_reg;
            p_reg <= '0;
        end
        else if (cmd.p_inc)
        begin
            p_reg <= p_reg + PW'(1);
        end
        else if (cmd.j_next)
        begin
            j_reg <= j_reg + ORD_W'(1);
            p_reg <= '0;
        end
        else if (cmd.split)
        begin
            j_reg <= j_reg - ORD_W'(1);
            p_reg <= {p_reg[PW-2:0], 1'b0};
        end
        else if (cmd.ftag)
        begin
            j_reg <= tag_ord;
            p_reg <= PW'(leaf >> tag_ord);
        end
        else if (cmd.merge)
        begin
            j_reg <= j_reg + ORD_W'(1);
            p_reg <= p_reg >> 1;
        end
        if (cmd.load)
        begin
            code_reg <= bba_pkg::RC_OK;
        end
        else if (cmd.set_code)
        begin
            code_reg <= cmd.code;
        end
        if (cmd.finish)
        begin
            res_code_reg <= code_reg;
            res_off_reg  <= (code_reg == bba_pkg::RC_OK) ? res_off32[bba_pkg::OFF_W-1:0] : '0;
            res_ord_reg  <= (code_reg == bba_pkg::RC_OK)
                            ? bba_pkg::ORDER_W'(32'(j_reg)) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + NAW'(1);
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign granted_offset = res_off_reg;
    assign granted_order  = res_ord_reg;
    assign status         = res_code_reg;

`ifndef NO_ASSERTIONS
    a_rise_by_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.finish))
        else $error("result shown without a finished transaction");
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid_reg && out_stall))
        else $error("result register overwritten while held");
    a_split_above_k: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.split |-> j_reg > k_reg)
        else $error("split below requested order");
    a_merge_below_top: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge |-> j_reg < TOP_ORD)
        else $error("merge past the whole heap");
`endif

endmodule

// ----- dv/tb_buddy_block_allocator.sv -----
// Testbench: buddy block allocator checked against a tree-bit predictor.
`timescale 1ns / 1ps

module tb_buddy_block_allocator;

    localparam int HEAP_BITS  = bba_pkg::HEAP_BITS_DEF;
    localparam int MIN_BITS   = bba_pkg::MIN_BLOCK_BITS_DEF;
    localparam int TOP        = HEAP_BITS - MIN_BITS;
    localparam int LEAVES     = 1 << TOP;
    localparam int NODES      = (2 << TOP) - 1;
    localparam int RAND_ITEMS = 750;
    localparam int OFF_W      = bba_pkg::OFF_W;
    localparam int ORDER_W    = bba_pkg::ORDER_W;
    localparam int SIZE_W     = bba_pkg::SIZE_W;

    typedef struct {
        logic [OFF_W-1:0]      offset;
        logic [ORDER_W-1:0]    order;
        bba_pkg::result_code_t code;
    } grant_t;

    typedef struct {
        logic              op;
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  offset;
    } request_t;

    class buddy_scoreboard;
        bit          free_bit[NODES];
        int unsigned order_tag[LEAVES];
        grant_t      pending[$];
        int unsigned live_blocks[$];
        int          errors;

        function new();
            foreach (free_bit[i]) free_bit[i] = 0;
            foreach (order_tag[i]) order_tag[i] = 0;
            free_bit[0] = 1;
            errors = 0;
        endfunction

        function longint unsigned node(int unsigned ord, longint unsigned pos);
            return ((longint'(1) << (TOP - ord)) - 1) + pos;
        endfunction

        function grant_t allocate(longint unsigned size);
            grant_t g;
            longint unsigned pos;
            int k, j;
            bit found;
            g.offset = '0;
            g.order = '0;
            k = 0;
            found = 0;
            pos = 0;
            while (k <= TOP && (longint'(1) << (k + MIN_BITS)) < size + 1) k++;
            if (k > TOP) begin
                g.code = bba_pkg::RC_TOO_LARGE;
                return g;
            end
            for (j = k; j <= TOP && !found; j++) begin
                for (pos = 0; pos < (longint'(1) << (TOP - j)); pos++)
                    if (free_bit[node(j, pos)]) begin
                        found = 1;
                        break;
                    end
                if (found) break;
            end
            if (!found) begin
                g.code = bba_pkg::RC_NO_FREE;
                return g;
            end
            free_bit[node(j, pos)] = 0;
            while (j > k) begin
                j--;
                pos = pos << 1;
                free_bit[node(j, pos + 1)] = 1;
            end
            order_tag[pos << k] = k + 1;
            live_blocks.push_back(32'(pos << (k + MIN_BITS)));
            g.offset = OFF_W'(pos << (k + MIN_BITS));
            g.order = ORDER_W'(k);
            g.code = bba_pkg::RC_OK;
            return g;
        endfunction

        function grant_t release_block(int unsigned off);
            grant_t g;
            int unsigned leaf, ord;
            longint unsigned pos;
            g.offset = '0;
            g.order = '0;
            g.code = bba_pkg::RC_BAD_FREE;
            if ((off >> HEAP_BITS) != 0 || (off & ((1 << MIN_BITS) - 1)) != 0) return g;
            leaf = off >> MIN_BITS;
            if (order_tag[leaf] == 0 || order_tag[leaf] - 1 > TOP) return g;
            ord = order_tag[leaf] - 1;
            order_tag[leaf] = 0;
            foreach (live_blocks[i])
                if (live_blocks[i] == off) begin
                    live_blocks.delete(i);
                    break;
                end
            pos = 64'(leaf >> ord);
            while (ord < TOP && free_bit[node(ord, pos ^ 1)]) begin
                free_bit[node(ord, pos ^ 1)] = 0;
                pos = pos >> 1;
                ord++;
            end
            free_bit[node(ord, pos)] = 1;
            g.offset = OFF_W'(pos << (ord + MIN_BITS));
            g.order = ORDER_W'(ord);
            g.code = bba_pkg::RC_OK;
            return g;
        endfunction

        function void note_request(request_t r);
            if (r.op == bba_pkg::OP_ALLOC) pending.push_back(allocate(64'(r.size)));
            else pending.push_back(release_block(32'(r.offset)));
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("MISMATCH @%0t: %s", $realtime, what);
        endtask

        task check_grant(logic [OFF_W-1:0] off, logic [ORDER_W-1:0] ord, logic [1:0] code);
            grant_t g;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction off=%0h", off));
                return;
            end
            g = pending.pop_front();
            if (code !== g.code)
                report_mismatch($sformatf("status %0d, want %0d", code, g.code));
            if (off !== g.offset)
                report_mismatch($sformatf("offset %0h, want %0h", off, g.offset));
            if (ord !== g.order)
                report_mismatch($sformatf("order %0d, want %0d", ord, g.order));
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                operation;
    logic [SIZE_W-1:0]   request_size;
    logic [OFF_W-1:0]    block_offset;
    logic                out_valid;
    logic                out_stall;
    logic [OFF_W-1:0]    granted_offset;
    logic [ORDER_W-1:0]  granted_order;
    logic [1:0]          status;

    buddy_scoreboard sb;
    request_t        directed[$];
    int              issued;
    int              cycle_count = 0;

    buddy_block_allocator u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .request_size   (request_size),
        .block_offset   (block_offset),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .granted_offset (granted_offset),
        .granted_order  (granted_order),
        .status         (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #500_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic bit idle_now();
        if (cycle_count > 40_000 && cycle_count < 400_000) return 0;
        return $urandom_range(99) < 6;
    endfunction

    task automatic add_req(logic op, int unsigned size, int unsigned off);
        request_t r;
        r.op = op;
        r.size = SIZE_W'(size);
        r.offset = OFF_W'(off);
        directed.push_back(r);
    endtask

    function automatic request_t random_req();
        request_t r;
        int unsigned ord, pick;
        r.size = SIZE_W'($urandom);
        r.offset = OFF_W'($urandom);
        pick = $urandom_range(99);
        if (sb.live_blocks.size() != 0 && pick < 45) begin
            r.op = bba_pkg::OP_FREE;
            if (pick < 38)
                r.offset = OFF_W'(sb.live_blocks[$urandom_range(sb.live_blocks.size() - 1)]);
            else if (pick < 41)
                r.offset = r.offset & ~OFF_W'((1 << MIN_BITS) - 1);
        end
        else begin
            r.op = bba_pkg::OP_ALLOC;
            if (pick < 92) begin
                ord = $urandom_range(TOP);
                if (ord == 0) r.size = SIZE_W'($urandom_range((1 << MIN_BITS) - 1));
                else r.size = SIZE_W'($urandom_range((1 << (ord + MIN_BITS)) - 1,
                                                     1 << (ord + MIN_BITS - 1)));
            end
        end
        return r;
    endfunction

    task automatic put_req(request_t r);
        in_valid     <= 1'b1;
        operation    <= r.op;
        request_size <= r.size;
        block_offset <= r.offset;
    endtask

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        request_t r;
        bit       accepted;
        sb = new();
        issued       = 0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = bba_pkg::OP_ALLOC;
        request_size = '0;
        block_offset = '0;
        add_req(bba_pkg::OP_ALLOC, 65535, 0);
        add_req(bba_pkg::OP_ALLOC, 0, 0);
        add_req(bba_pkg::OP_FREE, 0, 0);
        add_req(bba_pkg::OP_FREE, 0, 0);
        add_req(bba_pkg::OP_FREE, 1, 0);
        add_req(bba_pkg::OP_FREE, 0, 65535);
        add_req(bba_pkg::OP_FREE, 0, 64);
        add_req(bba_pkg::OP_ALLOC, 65536, 0);
        add_req(bba_pkg::OP_ALLOC, 131071, 0);
        add_req(bba_pkg::OP_ALLOC, 31, 0);
        add_req(bba_pkg::OP_ALLOC, 32, 0);
        add_req(bba_pkg::OP_ALLOC, 0, 0);
        add_req(bba_pkg::OP_ALLOC, 0, 0);
        add_req(bba_pkg::OP_ALLOC, 32767, 0);
        add_req(bba_pkg::OP_ALLOC, 32767, 0);
        add_req(bba_pkg::OP_FREE, 0, 64);
        add_req(bba_pkg::OP_FREE, 0, 0);
        add_req(bba_pkg::OP_FREE, 0, 32);
        add_req(bba_pkg::OP_FREE, 0, 96);
        add_req(bba_pkg::OP_FREE, 0, 32768);
        add_req(bba_pkg::OP_ALLOC, 65535, 0);
        add_req(bba_pkg::OP_FREE, 0, 0);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        forever
        begin
            @(posedge clk);
            accepted = in_valid && !in_stall;
            if (accepted)
            begin
                r.op = operation;
                r.size = request_size;
                r.offset = block_offset;
                sb.note_request(r);
                issued++;
            end
            if (!in_valid || accepted)
            begin
                if (issued >= RAND_ITEMS + 22)
                begin
                    in_valid <= 1'b0;
                    break;
                end
                else if (idle_now())
                    in_valid <= 1'b0;
                else if (directed.size() != 0)
                    put_req(directed.pop_front());
                else
                    put_req(random_req());
            end
        end
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_grant(granted_offset, granted_order, status);
            out_stall <= idle_now();
        end
    end

endmodule
